FILE: src/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
// Used by the entry unit and the top level; depends on nothing.
package lkv_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CFG_W = 5;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	localparam logic [CFG_W-1:0] CAP_RESET  = 5'd16;
	localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

	// Commands from the sequencer to the entry unit.
	typedef struct packed {
		logic start;
		logic scan;
		logic sweep;
		logic inc_all;
	} lkv_ctrl_t;

	// Results gathered by the entry unit during a scan.
	typedef struct packed {
		logic hit;
		logic pick_found;
		logic free_found;
	} lkv_stat_t;

endpackage

FILE: src/lkv_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; used for the key, value and rank stores.
module lkv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: src/lkv_entry_unit.sv
// Shared per-entry unit: key compare, LRU pick, free-slot search and rank aging.
// Handles one stored entry per cycle; depends on lkv_pkg.
module lkv_entry_unit #(
	parameter int IDX_W = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lkv_pkg::lkv_ctrl_t        ctrl,
	input  logic [IDX_W-1:0]          idx,
	input  logic                      entry_valid,
	input  logic [lkv_pkg::KEY_W-1:0] lookup_key,
	input  logic [lkv_pkg::KEY_W-1:0] key_data,
	input  logic [IDX_W-1:0]          rank_data,
	input  logic [IDX_W-1:0]          touch_rank,
	output lkv_pkg::lkv_stat_t        stat,
	output logic [IDX_W-1:0]          hit_idx,
	output logic [IDX_W-1:0]          hit_rank,
	output logic [IDX_W-1:0]          pick_idx,
	output logic [IDX_W-1:0]          free_idx,
	output logic [IDX_W-1:0]          rank_new,
	output logic                      rank_we
);

	import lkv_pkg::*;

	logic             hit_q;
	logic             pick_found_q;
	logic             free_found_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [IDX_W-1:0] hit_rank_q;
	logic [IDX_W-1:0] pick_idx_q;
	logic [IDX_W-1:0] pick_rank_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             key_match;
	logic             older;
	logic             bump;

	assign key_match = entry_valid && (key_data == lookup_key);
	assign older     = !pick_found_q || (rank_data > pick_rank_q);
	assign bump      = entry_valid && (ctrl.inc_all || (rank_data < touch_rank));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q        <= 1'b0;
			pick_found_q <= 1'b0;
			free_found_q <= 1'b0;
		end else if (ctrl.start) begin
			hit_q        <= 1'b0;
			pick_found_q <= 1'b0;
			free_found_q <= 1'b0;
		end else if (ctrl.scan) begin
			if (key_match) begin
				hit_q <= 1'b1;
			end
			if (entry_valid && older) begin
				pick_found_q <= 1'b1;
			end
			if (!entry_valid) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.scan) begin
			if (key_match) begin
				hit_idx_q  <= idx;
				hit_rank_q <= rank_data;
			end
			if (entry_valid && older) begin
				pick_idx_q  <= idx;
				pick_rank_q <= rank_data;
			end
			// Only the lowest free slot is kept.
			if (!entry_valid && !free_found_q) begin
				free_idx_q <= idx;
			end
		end
	end

	assign stat.hit        = hit_q;
	assign stat.pick_found = pick_found_q;
	assign stat.free_found = free_found_q;
	assign hit_idx         = hit_idx_q;
	assign hit_rank        = hit_rank_q;
	assign pick_idx        = pick_idx_q;
	assign free_idx        = free_idx_q;
	assign rank_new        = rank_data + IDX_W'(1);
	assign rank_we         = ctrl.sweep && bump;

endmodule

FILE: src/lru_key_value_cache.sv
// Top level of the LRU key-value cache: sequencer, valid bits, entry count, stores.
// Depends on lkv_pkg, lkv_ram and lkv_entry_unit.
//
// Usage: each input beat carries op (get or put), lookup_key and write_value.
// Each input beat yields exactly one output beat with found and read_value.
// A get hit returns the stored value; every other beat returns all ones.
// The input side takes one beat at a time: in_stall is high from the beat
// until the sequencer is back in its idle state.
// Between one accepted beat and the next, the cache makes one pass over all
// entries through the shared entry unit to search, then, for all but a get miss,
// one more pass through the rank store to age ranks. The output beat shows up
// in the same cycle in which the next input beat can be taken.
// The result sits in an output register; while out_stall holds it there the
// next input beat is still accepted and processed, and waits at its end.
// cfg_write_en writes the capacity register; 0 acts as 1 and values above
// MAX_ENTRIES act as MAX_ENTRIES. Write it only while the cache is idle.
// Reset clears all valid bits, the entry count and the output register, and
// sets the capacity to 16. The stores need no clearing pass.
module lru_key_value_cache #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [lkv_pkg::CFG_W-1:0]        cfg_write_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             op,
	input  logic signed [lkv_pkg::KEY_W-1:0] lookup_key,
	input  logic signed [lkv_pkg::VAL_W-1:0] write_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             found,
	output logic signed [lkv_pkg::VAL_W-1:0] read_value
);

	import lkv_pkg::*;

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_VREAD = 3'd2;
	localparam logic [2:0] S_SWEEP = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]       state_q;
	logic [CFG_W-1:0] cap_reg_q;
	logic [CNT_W-1:0] count_q;
	logic             valid_q [MAX_ENTRIES];
	logic [CNT_W-1:0] idx_q;
	logic             rd_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] wval_q;
	logic             hit_q;
	logic [VAL_W-1:0] rval_q;
	logic [IDX_W-1:0] target_q;
	logic [IDX_W-1:0] touch_rank_q;
	logic             inc_all_q;
	logic             insert_q;

	logic             out_valid_q;
	logic             out_found_q;
	logic [VAL_W-1:0] out_value_q;

	lkv_ctrl_t        ctrl;
	lkv_stat_t        stat;
	logic [IDX_W-1:0] hit_idx;
	logic [IDX_W-1:0] hit_rank;
	logic [IDX_W-1:0] pick_idx;
	logic [IDX_W-1:0] free_idx;
	logic [IDX_W-1:0] rank_new;
	logic             unit_rank_we;

	logic [KEY_W-1:0] key_rd;
	logic [VAL_W-1:0] val_rd;
	logic [IDX_W-1:0] rank_rd;

	logic             in_accept;
	logic             pass_end;
	logic             issue;
	logic [CMP_W-1:0] cap_now;
	logic             full;
	logic             evict;
	logic             slot_ok;
	logic [IDX_W-1:0] slot;
	logic             can_load;

	logic             key_we;
	logic             val_we;
	logic             rank_we;
	logic [IDX_W-1:0] rank_wa;
	logic [IDX_W-1:0] rank_wd;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign issue     = (idx_q < CNT_W'(MAX_ENTRIES));
	assign pass_end  = !issue && !rd_s1;
	assign can_load  = !out_valid_q || !out_stall;

	// Effective capacity: clamp the register to the range 1 to MAX_ENTRIES.
	always_comb begin
		if (cap_reg_q == '0) begin
			cap_now = CMP_W'(1);
		end else if (CMP_W'(cap_reg_q) > CMP_W'(MAX_ENTRIES)) begin
			cap_now = CMP_W'(MAX_ENTRIES);
		end else begin
			cap_now = CMP_W'(cap_reg_q);
		end
	end

	assign full  = (CMP_W'(count_q) >= cap_now);
	assign evict = full && stat.pick_found;

	// New entries go to the lowest free slot, counting the one just evicted.
	always_comb begin
		slot_ok = 1'b1;
		if (evict) begin
			slot = (stat.free_found && (free_idx < pick_idx)) ? free_idx : pick_idx;
		end else if (stat.free_found) begin
			slot = free_idx;
		end else begin
			slot    = free_idx;
			slot_ok = 1'b0;
		end
	end

	assign ctrl.start   = in_accept;
	assign ctrl.scan    = rd_s1 && (state_q == S_SCAN);
	assign ctrl.sweep   = rd_s1 && (state_q == S_SWEEP);
	assign ctrl.inc_all = inc_all_q;

	lkv_entry_unit #(
		.IDX_W(IDX_W)
	) u_unit (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.idx        (idx_s1),
		.entry_valid(valid_q[idx_s1]),
		.lookup_key (key_q),
		.key_data   (key_rd),
		.rank_data  (rank_rd),
		.touch_rank (touch_rank_q),
		.stat       (stat),
		.hit_idx    (hit_idx),
		.hit_rank   (hit_rank),
		.pick_idx   (pick_idx),
		.free_idx   (free_idx),
		.rank_new   (rank_new),
		.rank_we    (unit_rank_we)
	);

	assign key_we  = (state_q == S_FIN) && insert_q;
	assign val_we  = (state_q == S_FIN) && (op_q == OP_PUT);
	assign rank_we = ((state_q == S_SWEEP) && unit_rank_we) || (state_q == S_FIN);
	assign rank_wa = (state_q == S_FIN) ? target_q : idx_s1;
	assign rank_wd = (state_q == S_FIN) ? '0 : rank_new;

	lkv_ram #(
		.WIDTH(KEY_W),
		.DEPTH(MAX_ENTRIES)
	) u_key_ram (
		.clk    (clk),
		.wr_en  (key_we),
		.wr_addr(target_q),
		.wr_data(key_q),
		.rd_addr(idx_q[IDX_W-1:0]),
		.rd_data(key_rd)
	);

	lkv_ram #(
		.WIDTH(VAL_W),
		.DEPTH(MAX_ENTRIES)
	) u_val_ram (
		.clk    (clk),
		.wr_en  (val_we),
		.wr_addr(target_q),
		.wr_data(wval_q),
		.rd_addr(hit_idx),
		.rd_data(val_rd)
	);

	lkv_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_ENTRIES)
	) u_rank_ram (
		.clk    (clk),
		.wr_en  (rank_we),
		.wr_addr(rank_wa),
		.wr_data(rank_wd),
		.rd_addr(idx_q[IDX_W-1:0]),
		.rd_data(rank_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_reg_q <= CAP_RESET;
		end else if (cfg_write_en) begin
			cap_reg_q <= cfg_write_data;
		end
	end

	// Sequencer, entry count and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rd_s1   <= 1'b0;
			idx_q   <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else begin
			rd_s1 <= ((state_q == S_SCAN) || (state_q == S_SWEEP)) && issue;
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						idx_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end else if (pass_end) begin
						idx_q <= '0;
						if (op_q == OP_GET) begin
							state_q <= stat.hit ? S_VREAD : S_DONE;
						end else if (stat.hit) begin
							state_q <= S_SWEEP;
						end else begin
							if (evict) begin
								valid_q[pick_idx] <= 1'b0;
								count_q           <= count_q - CNT_W'(1);
							end
							state_q <= slot_ok ? S_SWEEP : S_DONE;
						end
					end
				end
				S_VREAD: begin
					state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end else if (pass_end) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (insert_q) begin
						valid_q[target_q] <= 1'b1;
						count_q           <= count_q + CNT_W'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (can_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[IDX_W-1:0];
		if (in_accept) begin
			op_q   <= op;
			key_q  <= lookup_key;
			wval_q <= write_value;
			rval_q <= MISS_VALUE;
		end
		if ((state_q == S_SCAN) && pass_end) begin
			hit_q        <= stat.hit;
			insert_q     <= (op_q == OP_PUT) && !stat.hit;
			inc_all_q    <= (op_q == OP_PUT) && !stat.hit;
			target_q     <= stat.hit ? hit_idx : slot;
			touch_rank_q <= hit_rank;
		end
		if (state_q == S_VREAD) begin
			rval_q <= val_rd;
		end
	end

	// Output register: a finished result waits here until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && can_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && can_load) begin
			out_found_q <= hit_q;
			out_value_q <= rval_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = out_found_q;
	assign read_value = out_value_q;

endmodule

FILE: test/lru_key_value_cache_tb.sv
// Self-checking testbench for lru_key_value_cache: directed and random get/put traffic,
// with an LRU predictor and an in-order check of every output beat.
// Depends on lkv_pkg and the lru_key_value_cache RTL.
module lru_key_value_cache_tb;
	import lkv_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int CACHE_DEPTH = 16;
	localparam int SETTLE_CYCLES = 2 * CACHE_DEPTH + 12;
	localparam int TIMEOUT_CYCLES = 600000;

	typedef struct {
		logic             op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] data;
	} cache_request_t;

	typedef struct {
		logic             hit;
		logic [VAL_W-1:0] data;
	} cache_reply_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_write_en;
	logic [CFG_W-1:0]        cfg_write_data;
	logic                    in_valid;
	logic                    in_stall;
	logic                    op;
	logic signed [KEY_W-1:0] lookup_key;
	logic signed [VAL_W-1:0] write_value;
	logic                    out_valid;
	logic                    out_stall;
	logic                    found;
	logic signed [VAL_W-1:0] read_value;

	cache_request_t queued_requests [$];
	cache_reply_t   due_replies [$];

	// Predicted cache contents.
	logic [KEY_W-1:0] stored_key [CACHE_DEPTH];
	logic [VAL_W-1:0] stored_val [CACHE_DEPTH];
	logic             slot_used [CACHE_DEPTH];
	logic [3:0]       slot_age [CACHE_DEPTH];
	int               used_count;
	logic [CFG_W-1:0] capacity_reg;

	int mismatch_count;
	logic in_taken;
	logic steady_flow;
	int in_gap;
	int out_hold_left;

	lru_key_value_cache #(
		.MAX_ENTRIES(CACHE_DEPTH)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.lookup_key    (lookup_key),
		.write_value   (write_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.found         (found),
		.read_value    (read_value)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Apply one get or put to the predicted contents and return the reply it gives.
	function automatic void lru_lookup_update(input logic req_op, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v, output logic hit, output logic [VAL_W-1:0] rd);
		int e;
		int victim;
		int slot;
		int cap;
		logic [3:0] age;
		e = -1;
		for (int i = 0; i < CACHE_DEPTH; i++)
			if (e < 0 && slot_used[i] && stored_key[i] == k)
				e = i;
		hit = (e >= 0);
		rd = MISS_VALUE;
		if (e >= 0) begin
			if (req_op == OP_GET)
				rd = stored_val[e];
			else
				stored_val[e] = v;
			age = slot_age[e];
			for (int i = 0; i < CACHE_DEPTH; i++)
				if (slot_used[i] && slot_age[i] < age)
					slot_age[i]++;
			slot_age[e] = 4'd0;
		end else if (req_op == OP_PUT) begin
			cap = capacity_reg;
			if (cap < 1)
				cap = 1;
			if (cap > CACHE_DEPTH)
				cap = CACHE_DEPTH;
			// A full cache drops exactly one entry, even when the capacity was lowered.
			if (used_count >= cap) begin
				victim = -1;
				for (int i = 0; i < CACHE_DEPTH; i++)
					if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
						victim = i;
				if (victim >= 0) begin
					slot_used[victim] = 1'b0;
					if (used_count > 0)
						used_count--;
				end
			end
			slot = -1;
			for (int i = 0; i < CACHE_DEPTH; i++)
				if (slot < 0 && !slot_used[i])
					slot = i;
			if (slot >= 0) begin
				for (int i = 0; i < CACHE_DEPTH; i++)
					if (slot_used[i])
						slot_age[i]++;
				stored_key[slot] = k;
				stored_val[slot] = v;
				slot_age[slot] = 4'd0;
				slot_used[slot] = 1'b1;
				used_count++;
			end
		end
	endfunction

	// Monitor: check the output beat first, since it always belongs to an earlier input beat.
	always @(posedge clk) begin
		cache_reply_t want;
		logic hit;
		logic [VAL_W-1:0] rd;
		in_taken = in_valid && !in_stall;
		if (arst_n) begin
			if (cfg_write_en)
				capacity_reg = cfg_write_data;
			if (out_valid && !out_stall) begin
				if (due_replies.size() == 0) begin
					$display("%0t: output beat with none due: found=%0b read_value=%h",
						$time, found, read_value);
					mismatch_count++;
				end else begin
					want = due_replies.pop_front();
					if (found !== want.hit) begin
						$display("%0t: found expected %0b actual %0b", $time, want.hit, found);
						mismatch_count++;
					end
					if (read_value !== want.data) begin
						$display("%0t: read_value expected %h actual %h",
							$time, want.data, read_value);
						mismatch_count++;
					end
				end
			end
			if (in_taken) begin
				lru_lookup_update(op, lookup_key, write_value, hit, rd);
				due_replies.push_back('{hit: hit, data: rd});
			end
		end
	end

	// Input driver: a new beat is presented only once the previous one was taken.
	always @(negedge clk) begin
		cache_request_t nxt;
		if (!in_valid || in_taken) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (queued_requests.size() > 0 &&
					(steady_flow || $urandom_range(0, 4) != 0)) begin
				nxt = queued_requests.pop_front();
				in_valid <= 1'b1;
				op <= nxt.op;
				lookup_key <= nxt.key;
				write_value <= nxt.data;
			end else begin
				in_valid <= 1'b0;
				if (!steady_flow && queued_requests.size() > 0)
					in_gap = $urandom_range(0, 9);
			end
		end
	end

	// Output stall in bursts.
	always @(negedge clk) begin
		if (out_hold_left > 0) begin
			out_hold_left--;
			out_stall <= 1'b1;
		end else if (!steady_flow && $urandom_range(0, 5) == 0) begin
			out_hold_left = $urandom_range(0, 9);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic enqueue_request(input logic req_op, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		queued_requests.push_back('{op: req_op, key: k, data: v});
	endtask

	// Hold the sender back until every reply is in and the block has settled.
	// The check runs at the rising edge, where the driven inputs are stable.
	task automatic drain_traffic();
		do
			@(posedge clk);
		while (queued_requests.size() > 0 || in_valid || due_replies.size() > 0 || in_stall);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_capacity(input logic [CFG_W-1:0] cap);
		drain_traffic();
		cfg_write_en <= 1'b1;
		cfg_write_data <= cap;
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// Random traffic over a small key pool so that hits, updates and evictions all occur.
	task automatic random_phase(input int count, input int pool_size);
		logic [KEY_W-1:0] key_pool [$];
		logic [KEY_W-1:0] k;
		for (int i = 0; i < pool_size; i++)
			key_pool.push_back($urandom);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 6) == 0)
				k = $urandom;
			else
				k = key_pool[$urandom_range(0, pool_size - 1)];
			enqueue_request(1'($urandom_range(0, 1)), k, $urandom);
		end
	endtask

	initial begin
		int phase_cap [8];
		int phase_pool [8];
		phase_cap = '{16, 4, 0, 31, 1, 9, 20, 16};
		phase_pool = '{20, 7, 3, 24, 2, 14, 18, 22};
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_write_data = '0;
		in_valid = 1'b0;
		op = OP_GET;
		lookup_key = '0;
		write_value = '0;
		out_stall = 1'b0;
		in_taken = 1'b0;
		steady_flow = 1'b0;
		in_gap = 0;
		out_hold_left = 0;
		mismatch_count = 0;
		used_count = 0;
		capacity_reg = CAP_RESET;
		for (int i = 0; i < CACHE_DEPTH; i++)
			slot_used[i] = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_capacity(5'd16);
		// Empty cache, extreme keys and values, hits, an update and a miss.
		enqueue_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
		enqueue_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		enqueue_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		enqueue_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);
		enqueue_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		enqueue_request(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		enqueue_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		enqueue_request(OP_PUT, 32'h0000_0000, 32'h1234_5678);
		enqueue_request(OP_GET, 32'h0000_0000, 32'h5555_AAAA);
		enqueue_request(OP_GET, 32'h0000_0001, 32'h0000_0000);
		// Fill to capacity; the next new key evicts the untouched entry.
		for (int i = 0; i < 12; i++)
			enqueue_request(OP_PUT, 32'h100 + i, $urandom);
		enqueue_request(OP_PUT, 32'h200, 32'hDEAD_BEEF);
		enqueue_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		// Capacity lowered under the count: a new key replaces one entry only.
		set_capacity(5'd3);
		enqueue_request(OP_PUT, 32'h300, 32'hA5A5_A5A5);
		enqueue_request(OP_GET, 32'h300, 32'h0000_0000);
		enqueue_request(OP_GET, 32'h101, 32'h0000_0000);

		for (int p = 0; p < 8; p++) begin
			set_capacity(CFG_W'(phase_cap[p]));
			if (p == 7)
				steady_flow = 1'b1;
			random_phase(212, phase_pool[p]);
		end

		drain_traffic();
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
